@@ src/u2h_pkg.sv @@
// Shared types, constants and helpers for the UTF-8 to UCS-2 hex converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package u2h_pkg;

	localparam int unsigned CapW      = 13;
	localparam int unsigned LenW      = 12;
	localparam int unsigned CharW     = 7;
	localparam int unsigned CodeW     = 16;
	localparam int unsigned PendW     = 2;
	localparam logic [CapW-1:0] CapReset = 13'd281;
	localparam logic [CapW-1:0] CapLimit = 13'd4096;

	localparam logic [0:0] StatusOk   = 1'b0;
	localparam logic [0:0] StatusFail = 1'b1;

	// One result item as it leaves the block.
	typedef struct packed {
		logic [CharW-1:0] hex_char_3;
		logic [CharW-1:0] hex_char_2;
		logic [CharW-1:0] hex_char_1;
		logic [CharW-1:0] hex_char_0;
		logic             chars_valid;
		logic             done_res;
		logic             status;
		logic [LenW-1:0]  hex_length;
	} u2h_res_t;

	// Uppercase ASCII hex digit for one nibble.
	function automatic logic [CharW-1:0] hex_ascii(input logic [3:0] nib);
		logic [CharW-1:0] c;
		if (nib < 4'd10) begin
			c = 7'h30 + {3'b000, nib};
		end else begin
			c = 7'h37 + {3'b000, nib};
		end
		return c;
	endfunction

endpackage : u2h_pkg

`default_nettype wire

@@ src/u2h_decode.sv @@
// Byte decoder: string state registers and single-pass decode of one byte.
// Depends on u2h_pkg for result type, widths and the hex digit helper.
`timescale 1ns / 1ps
`default_nettype none

module u2h_decode
	import u2h_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire logic [7:0]      text_byte,
	input  wire logic [CapW-1:0] out_capacity,
	output logic                 has_res,
	output u2h_res_t             res
);

	logic [PendW-1:0] pend_q, pend_d;
	logic [CodeW-1:0] acc_q, acc_d;
	logic [LenW-1:0]  len_q, len_d;
	logic             skip_q, skip_d;

	logic [CodeW-1:0] acc_shift;
	logic [PendW-1:0] pend_dec;
	logic [CodeW-1:0] lead_first;
	logic [PendW-1:0] lead_extra;
	logic             lead_ok;
	logic [CapW-1:0]  cap_eff;
	logic [CapW-1:0]  len_plus5;
	logic [CodeW-1:0] cp;
	logic             emit_cp;

	assign acc_shift = {acc_q[CodeW-7:0], text_byte[5:0]};
	assign pend_dec  = pend_q - 2'd1;
	assign cap_eff   = (out_capacity > CapLimit) ? CapLimit : out_capacity;
	assign len_plus5 = {1'b0, len_q} + 13'd5;

	always_comb begin
		lead_ok    = 1'b1;
		lead_first = '0;
		lead_extra = '0;
		if (!text_byte[7]) begin
			lead_first = {8'h00, text_byte};
		end else if (text_byte[7:5] == 3'b110) begin
			lead_first = {11'd0, text_byte[4:0]};
			lead_extra = 2'd1;
		end else if (text_byte[7:4] == 4'b1110) begin
			lead_first = {12'd0, text_byte[3:0]};
			lead_extra = 2'd2;
		end else begin
			lead_ok = 1'b0;
		end
	end

	always_comb begin
		pend_d  = pend_q;
		acc_d   = acc_q;
		len_d   = len_q;
		skip_d  = skip_q;
		has_res = 1'b0;
		emit_cp = 1'b0;
		cp      = '0;
		res     = '0;
		if (skip_q) begin
			if (text_byte == 8'h00) begin
				skip_d = 1'b0;
			end
		end else if (pend_q != '0) begin
			if (text_byte[7:6] != 2'b10) begin
				// malformed continuation or early terminator: fail the string
				has_res      = 1'b1;
				res.done_res = 1'b1;
				res.status   = StatusFail;
				pend_d       = '0;
				acc_d        = '0;
				len_d        = '0;
				skip_d       = (text_byte != 8'h00);
			end else begin
				acc_d  = acc_shift;
				pend_d = pend_dec;
				if (pend_dec == '0) begin
					emit_cp = 1'b1;
					cp      = acc_shift;
				end
			end
		end else if (text_byte == 8'h00) begin
			has_res        = 1'b1;
			res.done_res   = 1'b1;
			res.status     = StatusOk;
			res.hex_length = len_q;
			len_d          = '0;
			acc_d          = '0;
		end else if (!lead_ok) begin
			has_res      = 1'b1;
			res.done_res = 1'b1;
			res.status   = StatusFail;
			len_d        = '0;
			acc_d        = '0;
			skip_d       = 1'b1;
		end else if (len_plus5 > cap_eff) begin
			// truncate: report what fits and drop the rest of the string
			has_res        = 1'b1;
			res.done_res   = 1'b1;
			res.status     = StatusOk;
			res.hex_length = len_q;
			len_d          = '0;
			acc_d          = '0;
			skip_d         = 1'b1;
		end else if (lead_extra == '0) begin
			emit_cp = 1'b1;
			cp      = lead_first;
		end else begin
			acc_d  = lead_first;
			pend_d = lead_extra;
		end

		if (emit_cp) begin
			has_res         = 1'b1;
			res.hex_char_3  = hex_ascii(cp[15:12]);
			res.hex_char_2  = hex_ascii(cp[11:8]);
			res.hex_char_1  = hex_ascii(cp[7:4]);
			res.hex_char_0  = hex_ascii(cp[3:0]);
			res.chars_valid = 1'b1;
			len_d           = len_q + 12'd4;
			acc_d           = '0;
			pend_d          = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			acc_q  <= '0;
			len_q  <= '0;
			skip_q <= 1'b0;
		end else if (fire) begin
			pend_q <= pend_d;
			acc_q  <= acc_d;
			len_q  <= len_d;
			skip_q <= skip_d;
		end
	end

	a_len_mult4 : assert property (@(posedge clk) disable iff (!arst_n)
		len_q[1:0] == 2'b00)
		else $error("produced length lost its multiple of four");

	a_skip_clean : assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (pend_q == '0 && acc_q == '0 && len_q == '0))
		else $error("string state not cleared while dropping to terminator");

endmodule : u2h_decode

`default_nettype wire

@@ src/u2h_out_buf.sv @@
// Two-entry result buffer: output register plus skid register.
// Depends on u2h_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module u2h_out_buf
	import u2h_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire u2h_res_t push_res,
	input  wire logic     out_stall,
	output logic          out_valid,
	output u2h_res_t      out_res,
	output logic          full
);

	logic     main_valid_q, skid_valid_q;
	u2h_res_t main_q, skid_q;
	logic     take;

	assign take      = main_valid_q && !out_stall;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (take) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !take) begin
				skid_q <= push_res;
			end else begin
				main_q <= push_res;
			end
		end
	end

	a_skid_behind_main : assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held without an output entry");

	a_no_push_full : assert property (@(posedge clk) disable iff (!arst_n)
		!(push && skid_valid_q))
		else $error("result pushed into a full buffer");

	a_kind_exclusive : assert property (@(posedge clk) disable iff (!arst_n)
		main_valid_q |-> (main_q.chars_valid != main_q.done_res))
		else $error("result is neither or both of code point and done");

endmodule : u2h_out_buf

`default_nettype wire

@@ src/utf8_to_ucs2_hex_converter.sv @@
// Top level of the UTF-8 to UCS-2 hex converter: ports, capacity register,
// input register. Depends on u2h_pkg, u2h_decode and u2h_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to UCS-2 hex converter. Bytes of a UTF-8 string arrive one per
// transfer on text_byte, ended by a zero byte. Each completed 1-, 2- or
// 3-byte sequence gives one result carrying the code point as four
// uppercase ASCII hex digits (chars_valid high). The terminator gives a
// done result with status 0 and the number of hex characters produced.
// Any bad lead byte, stray or malformed continuation, or terminator inside a
// sequence gives done with status 1 and length 0. Before each lead the block
// checks that length + 5 fits within out_capacity (values above 4096 act as
// 4096); if not it finishes with status 0 and the length so far. After a
// finish other than a plain terminator or an early terminator, bytes are
// dropped silently up to and including the next zero byte. Many bytes give
// no result (dropped bytes, leads and middle continuations). Throughput is
// one byte per cycle while in_stall is low: a byte is held in the input
// register, is decoded in a single pass against the string state and lands
// in the output register, or the skid register while that one is held. A
// two-entry output buffer keeps in_stall free of any path from out_stall;
// input stalls only while both entries hold results the receiver has not
// taken. Write out_capacity through cfg_we/cfg_wdata only while idle.
module utf8_to_ucs2_hex_converter
	import u2h_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration
	input  wire logic             cfg_we,
	input  wire logic [CapW-1:0]  cfg_wdata,
	// byte input channel
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       text_byte,
	// result channel
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [CharW-1:0]      hex_char_3,
	output logic [CharW-1:0]      hex_char_2,
	output logic [CharW-1:0]      hex_char_1,
	output logic [CharW-1:0]      hex_char_0,
	output logic                  chars_valid,
	output logic                  done_res,
	output logic                  status,
	output logic [LenW-1:0]       hex_length
);

	logic [CapW-1:0] cap_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            buf_full;
	logic            fire;
	logic            has_res;
	u2h_res_t        dec_res;
	u2h_res_t        out_res;

	// Capacity register: plain write, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Hold the input register only while the output buffer is full.
	assign fire     = valid_s1 && !buf_full;
	assign in_stall = valid_s1 && buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input register: advance on every accepted transfer.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
		end
	end

	u2h_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.text_byte    (byte_s1),
		.out_capacity (cap_q),
		.has_res      (has_res),
		.res          (dec_res)
	);

	u2h_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && has_res),
		.push_res  (dec_res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.full      (buf_full)
	);

	assign hex_char_3  = out_res.hex_char_3;
	assign hex_char_2  = out_res.hex_char_2;
	assign hex_char_1  = out_res.hex_char_1;
	assign hex_char_0  = out_res.hex_char_0;
	assign chars_valid = out_res.chars_valid;
	assign done_res    = out_res.done_res;
	assign status      = out_res.status;
	assign hex_length  = out_res.hex_length;

endmodule : utf8_to_ucs2_hex_converter

`default_nettype wire

@@ test/tb_utf8_to_ucs2_hex_converter.sv @@
// Self-checking testbench for utf8_to_ucs2_hex_converter: directed and random UTF-8 strings,
// predicted per byte and checked per result field. Depends on u2h_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_utf8_to_ucs2_hex_converter;
	import u2h_pkg::*;

	// Ceiling on the whole run; the normal run needs a small fraction of this.
	localparam int unsigned CycleLimit  = 1_500_000;
	// Cycles to let a byte with no result leave the pipeline before a register write.
	localparam int unsigned SettleCycles = 6;
	// Bound on waiting for results once every byte has been transferred.
	localparam int unsigned DrainLimit  = 5000;
	localparam int unsigned RandomBytes = 250;
	// Enough single-byte code points to run into the 4092-character ceiling.
	localparam int unsigned LongRun     = 1030;

	localparam logic [CharW-1:0] AsciiZero   = 7'h30;
	localparam logic [CharW-1:0] AsciiUpperA = 7'h41;
	localparam logic [7:0]       Terminator  = 8'h00;

	typedef struct packed {
		logic [7:0] value;
		logic       hold;	// wait for every expected result before presenting this byte
	} text_item_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CapW-1:0]  cfg_wdata;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       text_byte;
	logic             out_valid;
	logic             out_stall;
	logic [CharW-1:0] hex_char_3;
	logic [CharW-1:0] hex_char_2;
	logic [CharW-1:0] hex_char_1;
	logic [CharW-1:0] hex_char_0;
	logic             chars_valid;
	logic             done_res;
	logic             status;
	logic [LenW-1:0]  hex_length;

	// Bytes waiting to be driven, and hex results awaited from the block.
	text_item_t text_q[$];
	u2h_res_t   hex_results_due[$];
	logic       hold_next;

	// Decoder state as the block should hold it.
	logic [CapW-1:0]  cap_shadow;
	logic [PendW-1:0] conts_left;
	logic [CodeW-1:0] code_acc;
	logic [LenW-1:0]  str_len;
	logic             skipping;

	// Run statistics.
	int unsigned mismatch_count;
	int unsigned decoded_bytes;
	int unsigned bytes_in;
	int unsigned code_points_seen;
	int unsigned strings_ended;
	int unsigned strings_failed;
	int unsigned cap_settings;
	int unsigned cycle_count;

	// Idle/stall pacing.
	int unsigned gap_left;
	int unsigned stall_left;
	logic        in_quiet;
	logic        out_quiet;

	utf8_to_ucs2_hex_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hex_char_3 (hex_char_3),
		.hex_char_2 (hex_char_2),
		.hex_char_1 (hex_char_1),
		.hex_char_0 (hex_char_0),
		.chars_valid(chars_valid),
		.done_res   (done_res),
		.status     (status),
		.hex_length (hex_length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic logic [CharW-1:0] nibble_to_ascii(input logic [3:0] n);
		if (n > 4'd9) begin
			return AsciiUpperA + {3'b000, n - 4'd10};
		end
		return AsciiZero + {3'b000, n};
	endfunction

	// End the string: a done result, string state cleared, optionally skip to the terminator.
	function automatic void finish_string(output u2h_res_t res, input logic st,
			input logic [LenW-1:0] len, input logic skip);
		res = '0;
		res.done_res   = 1'b1;
		res.status     = st;
		res.hex_length = len;
		conts_left = '0;
		code_acc   = '0;
		str_len    = '0;
		skipping   = skip;
	endfunction

	// Emit the assembled code point as four hex characters.
	function automatic void emit_code_point(output u2h_res_t res, input logic [CodeW-1:0] cp);
		res = '0;
		res.hex_char_3  = nibble_to_ascii(cp[15:12]);
		res.hex_char_2  = nibble_to_ascii(cp[11:8]);
		res.hex_char_1  = nibble_to_ascii(cp[7:4]);
		res.hex_char_0  = nibble_to_ascii(cp[3:0]);
		res.chars_valid = 1'b1;
		str_len    = str_len + LenW'(4);
		code_acc   = '0;
		conts_left = '0;
	endfunction

	// Advance the decoder by one byte; return 1 when the byte yields a result.
	function automatic logic decode_utf8_byte(input logic [7:0] b, output u2h_res_t res);
		logic [CodeW-1:0] lead_bits;
		logic [PendW-1:0] extra;
		int unsigned      cap_eff;
		res = '0;
		if (skipping) begin
			if (b == Terminator) begin
				skipping = 1'b0;
			end
			return 1'b0;
		end
		decoded_bytes++;
		if (conts_left != '0) begin
			// only 10xxxxxx continues a sequence; a terminator here ends without skipping
			if (b[7:6] != 2'b10) begin
				finish_string(res, StatusFail, '0, b != Terminator);
				return 1'b1;
			end
			code_acc   = {code_acc[CodeW-7:0], b[5:0]};
			conts_left = conts_left - 2'd1;
			if (conts_left == '0) begin
				emit_code_point(res, code_acc);
				return 1'b1;
			end
			return 1'b0;
		end
		if (b == Terminator) begin
			finish_string(res, StatusOk, str_len, 1'b0);
			return 1'b1;
		end
		// classify the lead before any capacity check
		if (!b[7]) begin
			lead_bits = {8'h00, b};
			extra     = 2'd0;
		end else if (b[7:5] == 3'b110) begin
			lead_bits = {11'h000, b[4:0]};
			extra     = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			lead_bits = {12'h000, b[3:0]};
			extra     = 2'd2;
		end else begin
			finish_string(res, StatusFail, '0, 1'b1);
			return 1'b1;
		end
		cap_eff = (cap_shadow > CapLimit) ? int'(CapLimit) : int'(cap_shadow);
		if (int'(str_len) + 5 > cap_eff) begin
			finish_string(res, StatusOk, str_len, 1'b1);
			return 1'b1;
		end
		if (extra == 2'd0) begin
			emit_code_point(res, lead_bits);
			return 1'b1;
		end
		code_acc   = lead_bits;
		conts_left = extra;
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Pacing: mostly short gaps, now and then a long one
	// ------------------------------------------------------------------

	function automatic int unsigned pick_idle(input logic quiet);
		int unsigned r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	// ------------------------------------------------------------------
	// Byte driver: present queued bytes, predict each transfer
	// ------------------------------------------------------------------

	always @(posedge clk) begin : drive_bytes
		text_item_t nxt;
		u2h_res_t   res;
		logic       launch;
		if (!arst_n) begin
			cap_shadow = CapReset;
			conts_left = '0;
			code_acc   = '0;
			str_len    = '0;
			skipping   = 1'b0;
			gap_left   = 0;
			in_valid  <= 1'b0;
		end else begin
			// track the register exactly when the block takes it
			if (cfg_we) begin
				cap_shadow = cfg_wdata;
			end
			if (in_valid && !in_stall) begin
				bytes_in++;
				if (decode_utf8_byte(text_byte, res)) begin
					hex_results_due.push_back(res);
				end
			end
			// hold a stalled byte; otherwise pick the next one or idle
			if (!in_valid || !in_stall) begin
				launch = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (text_q.size() != 0 &&
						!(text_q[0].hold && hex_results_due.size() != 0)) begin
					nxt      = text_q.pop_front();
					launch   = 1'b1;
					gap_left = pick_idle(in_quiet);
					if ($urandom_range(0, 99) == 0) begin
						in_quiet = ~in_quiet;
					end
				end
				in_valid <= launch;
				if (launch) begin
					text_byte <= nxt.value;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: compare each transfer with the oldest prediction
	// ------------------------------------------------------------------

	function automatic void compare_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		u2h_res_t want;
		if (!arst_n) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (hex_results_due.size() == 0) begin
					$error("result transferred with none expected");
					mismatch_count++;
				end else begin
					want = hex_results_due.pop_front();
					compare_field("hex_char_3", want.hex_char_3, hex_char_3);
					compare_field("hex_char_2", want.hex_char_2, hex_char_2);
					compare_field("hex_char_1", want.hex_char_1, hex_char_1);
					compare_field("hex_char_0", want.hex_char_0, hex_char_0);
					compare_field("chars_valid", want.chars_valid, chars_valid);
					compare_field("done_res", want.done_res, done_res);
					compare_field("status", want.status, status);
					compare_field("hex_length", want.hex_length, hex_length);
					if (want.chars_valid) begin
						code_points_seen++;
					end
					if (want.done_res) begin
						strings_ended++;
						if (want.status == StatusFail) begin
							strings_failed++;
						end
					end
				end
			end
			// back-pressure in bursts, with quiet stretches in between
			if (stall_left == 0 && !out_quiet && $urandom_range(0, 99) < 30) begin
				stall_left = pick_idle(1'b0);
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			if ($urandom_range(0, 199) == 0) begin
				out_quiet = ~out_quiet;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic void push_byte(input logic [7:0] b);
		text_item_t it;
		it.value  = b;
		it.hold   = hold_next;
		hold_next = 1'b0;
		text_q.push_back(it);
	endfunction

	function automatic void push_bytes(input logic [7:0] bs[]);
		foreach (bs[i]) begin
			push_byte(bs[i]);
		end
	endfunction

	// One well-formed 1-, 2- or 3-byte sequence with random content.
	function automatic void push_code_point();
		case ($urandom_range(0, 3))
			0, 1: begin
				push_byte(8'($urandom_range(1, 127)));
			end
			2: begin
				push_byte(8'hC0 | 8'($urandom_range(0, 31)));
				push_byte(8'h80 | 8'($urandom_range(0, 63)));
			end
			default: begin
				push_byte(8'hE0 | 8'($urandom_range(0, 15)));
				push_byte(8'h80 | 8'($urandom_range(0, 63)));
				push_byte(8'h80 | 8'($urandom_range(0, 63)));
			end
		endcase
	endfunction

	// One broken piece of text; set ended when it already closed the string.
	function automatic void push_fault(output logic ended);
		ended = 1'b0;
		case ($urandom_range(0, 4))
			0: begin
				// stray continuation
				push_byte(8'h80 | 8'($urandom_range(0, 63)));
			end
			1: begin
				// 4-byte or longer lead
				push_byte(8'($urandom_range(240, 255)));
			end
			2: begin
				// lead followed by a byte that is not a continuation
				push_byte($urandom_range(0, 1) ? 8'hC0 | 8'($urandom_range(0, 31))
						: 8'hE0 | 8'($urandom_range(0, 15)));
				push_byte($urandom_range(0, 1) ? 8'($urandom_range(1, 127))
						: 8'($urandom_range(192, 255)));
			end
			3: begin
				// terminator cuts a sequence short
				if ($urandom_range(0, 1)) begin
					push_byte(8'hC0 | 8'($urandom_range(0, 31)));
				end else begin
					push_byte(8'hE0 | 8'($urandom_range(0, 15)));
					if ($urandom_range(0, 1)) begin
						push_byte(8'h80 | 8'($urandom_range(0, 63)));
					end
				end
				push_byte(Terminator);
				ended = 1'b1;
			end
			default: begin
				push_byte(8'($urandom_range(0, 255)));
			end
		endcase
	endfunction

	function automatic void push_string(input int unsigned n_cp, input logic faulty);
		logic ended;
		ended = 1'b0;
		for (int unsigned i = 0; i < n_cp && !ended; i++) begin
			if (faulty && $urandom_range(0, 99) < 8) begin
				push_fault(ended);
			end else begin
				push_code_point();
			end
		end
		if (!ended) begin
			push_byte(Terminator);
		end
	endfunction

	// A long string of single-byte code points.
	function automatic void push_ascii_string(input int unsigned n_cp);
		for (int unsigned i = 0; i < n_cp; i++) begin
			push_byte(8'($urandom_range(1, 127)));
		end
		push_byte(Terminator);
	endfunction

	// Wait until every byte is transferred and every result has arrived, then let the
	// pipeline empty of bytes that give no result.
	task automatic wait_idle();
		int unsigned guard;
		guard = 0;
		@(negedge clk);
		while (text_q.size() != 0 || in_valid) begin
			@(negedge clk);
		end
		while (hex_results_due.size() != 0 && guard < DrainLimit) begin
			@(negedge clk);
			guard++;
		end
		if (hex_results_due.size() != 0) begin
			$error("%0d expected results never arrived", hex_results_due.size());
			mismatch_count++;
			hex_results_due.delete();
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CapW-1:0] value);
		wait_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cap_settings++;
	endtask

	initial begin : run_test
		logic [CapW-1:0] cap;
		int unsigned     random_base;
		int unsigned     r;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		text_byte      = '0;
		out_stall      = 1'b0;
		hold_next      = 1'b0;
		in_quiet       = 1'b0;
		out_quiet      = 1'b0;
		mismatch_count = 0;
		decoded_bytes  = 0;
		bytes_in       = 0;
		code_points_seen = 0;
		strings_ended  = 0;
		strings_failed = 0;
		cap_settings   = 0;
		cycle_count    = 0;

		// Directed text at the reset capacity: ASCII 'A' and the top ASCII value, 2- and 3-byte limits.
		push_bytes('{8'h41, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
				Terminator});
		// empty string, presented only once everything before it has come out
		hold_next = 1'b1;
		push_byte(Terminator);
		// stray continuation, then the rest of the string is dropped
		push_bytes('{8'h80, 8'h58, Terminator});
		// 4-byte lead is unsupported
		push_bytes('{8'hF0, Terminator});
		// malformed continuation
		push_bytes('{8'hC3, 8'h41, Terminator});
		// terminator inside a sequence fails and ends at once; the next string decodes
		push_bytes('{8'hE2, 8'h82, Terminator, 8'h41, Terminator});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// zero capacity: truncate at the first lead; a bad lead still fails
		write_capacity('0);
		push_bytes('{8'h41, Terminator, 8'hFF, Terminator});
		// capacity checked at leads only: the 3-byte sequence completes, the next lead truncates
		write_capacity(CapW'(13));
		push_bytes('{8'h41, 8'h42, 8'hE2, 8'h82, 8'hAC, 8'h43, Terminator});
		// capacity one: truncate with length 0, the dropped terminator gives nothing
		write_capacity(CapW'(1));
		push_bytes('{8'h41, Terminator, Terminator});
		// top of the register acts as the largest buffer: cut at 4092 characters
		write_capacity('1);
		push_ascii_string(LongRun);

		// Random strings, mostly well-formed, under varying capacities.
		random_base = decoded_bytes;
		while (decoded_bytes - random_base < RandomBytes) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				cap = CapW'($urandom_range(0, 60));
			end else if (r < 70) begin
				cap = CapReset;
			end else begin
				cap = CapW'($urandom_range(0, 8191));
			end
			write_capacity(cap);
			repeat ($urandom_range(3, 12)) begin
				if ($urandom_range(0, 99) < 4) begin
					hold_next = 1'b1;
				end
				if ($urandom_range(0, 99) < 10) begin
					push_byte(8'($urandom_range(0, 255)));
				end
				push_string($urandom_range(0, 12), $urandom_range(0, 99) < 35);
			end
			wait_idle();
		end

		wait_idle();
		$display("Transferred %0d bytes (%0d decoded) under %0d capacity settings.",
				bytes_in, decoded_bytes, cap_settings);
		$display("Checked %0d code points and %0d string endings, %0d of them failures.",
				code_points_seen, strings_ended, strings_failed);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
